### hw/rtl/dcs_pkg.sv
// Shared types and constants for the dual charger supervisor.
// No dependencies; imported by dcs_cfg, dcs_charger and the top level.
package dcs_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PIN   = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    localparam logic [7:0] REG_ID     = 8'd0;
    localparam logic [7:0] REG_VER    = 8'd1;
    localparam logic [7:0] REG_STAT_A = 8'd2;
    localparam logic [7:0] REG_STAT_B = 8'd3;
    localparam logic [7:0] REG_SOFT_A = 8'd4;
    localparam logic [7:0] REG_SOFT_B = 8'd5;
    localparam logic [7:0] READ_UNKNOWN = 8'hFF;

    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_LOCKOUT = 2'd1;
    localparam logic [1:0] CFG_BOARD   = 2'd2;
    localparam logic [1:0] CFG_VERSION = 2'd3;

    localparam logic [15:0] WINDOW_RST  = 16'd60;
    localparam logic [15:0] LOCKOUT_RST = 16'd1200;
    localparam logic [7:0]  BOARD_RST   = 8'h30;
    localparam logic [7:0]  VERSION_RST = 8'd1;

    localparam int PADDR_W = 4;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] lockout;
        logic [7:0]  board_id;
        logic [7:0]  version;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic pin_evt;
        logic soft_wr;
        logic soft_val;
    } t_chg_ctl;

endpackage

### hw/rtl/dcs_if.sv
// Valid/ready channel interfaces for the supervisor's item and result streams.
// Depends on nothing.
interface dcs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       charger_sel;
    logic [2:0] pins_a;
    logic [2:0] pins_b;
    logic [7:0] reg_addr;
    logic [7:0] write_data;

    modport source (output valid, operation, charger_sel, pins_a, pins_b, reg_addr,
                    write_data, input ready);
    modport sink (input valid, operation, charger_sel, pins_a, pins_b, reg_addr,
                  write_data, output ready);
endinterface

interface dcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       enable_a_driven;
    logic       enable_b_driven;

    modport source (output valid, read_data, enable_a_driven, enable_b_driven,
                    input ready);
    modport sink (input valid, read_data, enable_a_driven, enable_b_driven,
                  output ready);
endinterface

### hw/rtl/dcs_cfg.sv
// APB-style configuration register file: restart window, lockout, id, version.
// Depends on dcs_pkg.
module dcs_cfg
    import dcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window   <= WINDOW_RST;
            r_cfg.lockout  <= LOCKOUT_RST;
            r_cfg.board_id <= BOARD_RST;
            r_cfg.version  <= VERSION_RST;
        end else if (wr_en) begin
            case (idx)
                CFG_WINDOW:  r_cfg.window   <= pwdata[15:0];
                CFG_LOCKOUT: r_cfg.lockout  <= pwdata[15:0];
                CFG_BOARD:   r_cfg.board_id <= pwdata[7:0];
                CFG_VERSION: r_cfg.version  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_WINDOW:  prdata = {16'd0, r_cfg.window};
            CFG_LOCKOUT: prdata = {16'd0, r_cfg.lockout};
            CFG_BOARD:   prdata = {24'd0, r_cfg.board_id};
            CFG_VERSION: prdata = {24'd0, r_cfg.version};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

### hw/rtl/dcs_charger.sv
// Per-charger loop detector: stop stamp, lockout counter, enable line, status byte.
// Depends on dcs_pkg.
module dcs_charger
    import dcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chg_ctl    i_ctl,
    input  logic [2:0]  i_pins,
    input  logic [31:0] i_seconds,
    input  t_cfg        i_cfg,
    output logic [7:0]  o_status,
    output logic        o_soft,
    output logic        o_en_next
);

    logic        r_was, n_was;
    logic [31:0] r_stop, n_stop;
    logic        r_valid, n_valid;
    logic [15:0] r_lock, n_lock;
    logic        r_soft, n_soft;
    logic        r_en, n_en;
    logic        pg_on, stat1_on, stat2_off;
    logic [31:0] elapsed;

    assign pg_on     = ~i_pins[0];
    assign stat1_on  = ~i_pins[1];
    assign stat2_off = i_pins[2];
    assign elapsed   = i_seconds - r_stop;

    always_comb begin
        n_was   = r_was;
        n_stop  = r_stop;
        n_valid = r_valid;
        n_lock  = r_lock;
        n_soft  = r_soft;
        n_en    = r_en;
        if (i_ctl.tick) begin
            if (r_lock != 16'd0) begin
                n_lock = r_lock - 16'd1;
                if (r_lock == 16'd1 && !r_soft) begin
                    n_en = 1'b0;
                end
            end
        end else if (i_ctl.pin_evt) begin
            if (pg_on) begin
                if (r_was && !stat1_on) begin
                    n_stop  = i_seconds;
                    n_valid = 1'b1;
                end else if (stat1_on && stat2_off && r_valid &&
                             elapsed < {16'd0, i_cfg.window}) begin
                    n_en   = 1'b1;
                    n_lock = i_cfg.lockout;
                end
            end
            n_was = stat1_on;
        end else if (i_ctl.soft_wr) begin
            n_soft  = i_ctl.soft_val;
            n_lock  = 16'd0;
            n_valid = 1'b0;
            n_en    = i_ctl.soft_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was   <= 1'b0;
            r_valid <= 1'b0;
            r_lock  <= 16'd0;
            r_soft  <= 1'b0;
            r_en    <= 1'b0;
        end else begin
            r_was   <= n_was;
            r_valid <= n_valid;
            r_lock  <= n_lock;
            r_soft  <= n_soft;
            r_en    <= n_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stop <= n_stop;
    end

    assign o_status  = {1'b0, r_valid, r_soft, (r_lock != 16'd0), ~r_en, ~i_pins};
    assign o_soft    = r_soft;
    assign o_en_next = n_en;

endmodule

### hw/rtl/dual_charger_supervisor.sv
// Dual charger supervisor top level: second counter, two charger units, result register.
// Result valid in the cycle after accept; one item per cycle while results are taken.
// Input ready stays high while the result register is empty or being taken.
// Synchronous active-low reset clears all control state and loads the default
// configuration. Depends on dcs_pkg, dcs_if, dcs_cfg and dcs_charger.
module dual_charger_supervisor
    import dcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    dcs_in_if.sink             i_in,
    dcs_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg        cfg;
    logic        accept;
    t_op         op;
    logic [31:0] r_seconds;
    t_chg_ctl    ctl_a, ctl_b;
    logic [7:0]  stat_a, stat_b;
    logic        soft_a, soft_b;
    logic        en_a_next, en_b_next;
    logic [7:0]  rd;
    logic        r_out_valid;
    logic [7:0]  r_rd;
    logic        r_en_a, r_en_b;

    dcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign op         = t_op'(i_in.operation);

    always_comb begin
        ctl_a.tick     = accept && op == OP_TICK;
        ctl_a.pin_evt  = accept && op == OP_PIN && !i_in.charger_sel;
        ctl_a.soft_wr  = accept && op == OP_WRITE && i_in.reg_addr == REG_SOFT_A;
        ctl_a.soft_val = i_in.write_data != 8'd0;
        ctl_b.tick     = ctl_a.tick;
        ctl_b.pin_evt  = accept && op == OP_PIN && i_in.charger_sel;
        ctl_b.soft_wr  = accept && op == OP_WRITE && i_in.reg_addr == REG_SOFT_B;
        ctl_b.soft_val = ctl_a.soft_val;
    end

    dcs_charger u_chg_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl_a),
        .i_pins    (i_in.pins_a),
        .i_seconds (r_seconds),
        .i_cfg     (cfg),
        .o_status  (stat_a),
        .o_soft    (soft_a),
        .o_en_next (en_a_next)
    );

    dcs_charger u_chg_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl_b),
        .i_pins    (i_in.pins_b),
        .i_seconds (r_seconds),
        .i_cfg     (cfg),
        .o_status  (stat_b),
        .o_soft    (soft_b),
        .o_en_next (en_b_next)
    );

    always_comb begin
        rd = 8'd0;
        if (op == OP_READ) begin
            case (i_in.reg_addr)
                REG_ID:     rd = cfg.board_id;
                REG_VER:    rd = cfg.version;
                REG_STAT_A: rd = stat_a;
                REG_STAT_B: rd = stat_b;
                REG_SOFT_A: rd = {7'd0, soft_a};
                REG_SOFT_B: rd = {7'd0, soft_b};
                default:    rd = READ_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds   <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl_a.tick) begin
                r_seconds <= r_seconds + 32'd1;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd   <= rd;
            r_en_a <= en_a_next;
            r_en_b <= en_b_next;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.read_data       = r_rd;
    assign o_out.enable_a_driven = r_en_a;
    assign o_out.enable_b_driven = r_en_b;

endmodule
